[rtl/ccpd_pkg.sv]
// ----------------------------------------------------------------------------
// ccpd_pkg: shared definitions for the CRC-checked packet deframer
// Status codes, configuration register indexes, queue descriptor type and
// the CRC-16/CCITT byte update used by the deframer modules.
// ----------------------------------------------------------------------------
package ccpd_pkg;

	localparam int PACKET_BYTES_DEF = 32;
	localparam int START_LEN        = 5;
	localparam int START_W          = 8 * START_LEN;
	localparam int CFG_IDX_W        = 1;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_START_PATTERN = 1'b0,
		CFG_STOP_VALUE    = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_STOP_ERR = 2'd1,
		ST_CRC_ERR  = 2'd2
	} status_t;

	typedef enum logic {
		FR_HUNT,
		FR_COLLECT
	} front_state_t;

	typedef enum logic {
		BK_IDLE,
		BK_EMIT
	} back_state_t;

	// One finished packet as handed from the front to the back.
	typedef struct packed {
		logic    buf_sel;
		status_t status;
	} desc_t;

	// CRC-16/CCITT, polynomial 0x1021, one byte, most significant bit first.
	function automatic logic [15:0] crc_update(logic [15:0] crc, logic [7:0] b);
		logic [7:0] x;
		x = crc[15:8] ^ b;
		x = x ^ (x >> 4);
		return {crc[7:0], 8'h00} ^ {x[3:0], 12'h000} ^ {3'b000, x, 5'b00000}
			^ {8'h00, x};
	endfunction

	// Byte idx of the start pattern, the first byte being in the top bits.
	function automatic logic [7:0] pattern_byte(logic [START_W-1:0] pattern,
		logic [2:0] idx);
		logic [7:0] r;
		unique case (idx)
			3'd0:    r = pattern[39:32];
			3'd1:    r = pattern[31:24];
			3'd2:    r = pattern[23:16];
			3'd3:    r = pattern[15:8];
			default: r = pattern[7:0];
		endcase
		return r;
	endfunction

endpackage

[rtl/ccpd_front.sv]
// ----------------------------------------------------------------------------
// ccpd_front: start pattern hunt and packet collection
// Searches for the start pattern, collects the packet into one of two
// buffers, runs the CRC and posts a descriptor for each finished packet.
// ----------------------------------------------------------------------------
module ccpd_front #(
	parameter int PACKET_BYTES = ccpd_pkg::PACKET_BYTES_DEF,
	parameter int POS_W        = $clog2(PACKET_BYTES)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [ccpd_pkg::START_W-1:0]  start_pattern,
	input  logic [7:0]                    stop_value,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    rx_byte,
	output logic                          mem_we,
	output logic [POS_W:0]                mem_waddr,
	output logic [7:0]                    mem_wdata,
	output logic                          push,
	output ccpd_pkg::desc_t               push_desc,
	input  logic                          q_full,
	input  logic [1:0]                    busy_clr
);

	localparam logic [POS_W-1:0] LAST_POS  = POS_W'(PACKET_BYTES - 1);
	localparam logic [POS_W-1:0] CRC_LO    = POS_W'(PACKET_BYTES - 3);
	localparam logic [POS_W-1:0] CRC_HI    = POS_W'(PACKET_BYTES - 2);
	localparam logic [POS_W-1:0] FIRST_POS = POS_W'(ccpd_pkg::START_LEN);

	ccpd_pkg::front_state_t state_q, state_d;
	logic [31:0]      recent_q;
	logic [POS_W-1:0] pos_q;
	logic [15:0]      crc_q;
	logic [15:0]      crc_start;
	logic [7:0]       crc_lo_q, crc_hi_q;
	logic             wr_buf_q;
	logic [1:0]       busy_q, busy_d;
	logic             accept, match, last_pos, good;
	ccpd_pkg::status_t verdict;

	always_comb begin
		logic [15:0] c;
		c = ccpd_pkg::CRC_INIT;
		for (int i = 0; i < ccpd_pkg::START_LEN; i++) begin
			c = ccpd_pkg::crc_update(c,
				start_pattern[8*(ccpd_pkg::START_LEN-1-i) +: 8]);
		end
		crc_start = c;
	end

	assign match    = {recent_q, rx_byte} == start_pattern;
	assign last_pos = pos_q == LAST_POS;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		if (rx_byte != stop_value) begin
			verdict = ccpd_pkg::ST_STOP_ERR;
		end else if ({crc_hi_q, crc_lo_q} != crc_q) begin
			verdict = ccpd_pkg::ST_CRC_ERR;
		end else begin
			verdict = ccpd_pkg::ST_OK;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ccpd_pkg::FR_HUNT: begin
				if (accept && match) state_d = ccpd_pkg::FR_COLLECT;
			end
			ccpd_pkg::FR_COLLECT: begin
				if (accept && last_pos) state_d = ccpd_pkg::FR_HUNT;
			end
			default: state_d = ccpd_pkg::FR_HUNT;
		endcase
	end

	// Outputs.
	always_comb begin
		in_stall = 1'b0;
		mem_we   = 1'b0;
		push     = 1'b0;
		unique case (state_q)
			ccpd_pkg::FR_HUNT: begin
			end
			ccpd_pkg::FR_COLLECT: begin
				in_stall = busy_q[wr_buf_q] || q_full;
				mem_we   = accept;
				push     = accept && last_pos;
			end
			default: begin
			end
		endcase
		mem_waddr        = {wr_buf_q, pos_q};
		mem_wdata        = rx_byte;
		push_desc.buf_sel = wr_buf_q;
		push_desc.status  = verdict;
	end

	assign good = push && (verdict == ccpd_pkg::ST_OK);

	always_comb begin
		busy_d = busy_q & ~busy_clr;
		if (good) busy_d[wr_buf_q] = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ccpd_pkg::FR_HUNT;
			recent_q <= '0;
			pos_q    <= '0;
			crc_q    <= ccpd_pkg::CRC_INIT;
			wr_buf_q <= 1'b0;
			busy_q   <= '0;
		end else begin
			state_q <= state_d;
			busy_q  <= busy_d;
			if (good) wr_buf_q <= ~wr_buf_q;
			if (accept) begin
				if (state_q == ccpd_pkg::FR_HUNT) begin
					if (match) begin
						recent_q <= '0;
						pos_q    <= FIRST_POS;
						crc_q    <= crc_start;
					end else begin
						recent_q <= {recent_q[23:0], rx_byte};
					end
				end else if (last_pos) begin
					pos_q <= '0;
					crc_q <= ccpd_pkg::CRC_INIT;
				end else begin
					pos_q <= pos_q + 1'b1;
					if (pos_q < CRC_LO) crc_q <= ccpd_pkg::crc_update(crc_q, rx_byte);
				end
			end
		end
	end

	// Received CRC field, low byte first.
	always_ff @(posedge clk) begin
		if (accept && state_q == ccpd_pkg::FR_COLLECT) begin
			if (pos_q == CRC_LO) crc_lo_q <= rx_byte;
			if (pos_q == CRC_HI) crc_hi_q <= rx_byte;
		end
	end

endmodule

[rtl/ccpd_queue.sv]
// ----------------------------------------------------------------------------
// ccpd_queue: two-entry descriptor queue
// Holds finished-packet descriptors between the front and the back.
// ----------------------------------------------------------------------------
module ccpd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ccpd_pkg::desc_t push_desc,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output ccpd_pkg::desc_t head
);

	ccpd_pkg::desc_t entry_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign full       = count_q == 2'd2;
	assign head_valid = count_q != 2'd0;
	assign head       = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_desc;
	end

endmodule

[rtl/ccpd_back.sv]
// ----------------------------------------------------------------------------
// ccpd_back: packet buffer and result emitter
// Holds the two packet buffers and plays out each descriptor as a run of
// packet bytes or a single failure status through a registered output.
// ----------------------------------------------------------------------------
module ccpd_back #(
	parameter int PACKET_BYTES = ccpd_pkg::PACKET_BYTES_DEF,
	parameter int POS_W        = $clog2(PACKET_BYTES)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [ccpd_pkg::START_W-1:0] start_pattern,
	input  logic                         mem_we,
	input  logic [POS_W:0]               mem_waddr,
	input  logic [7:0]                   mem_wdata,
	input  logic                         head_valid,
	input  ccpd_pkg::desc_t              head,
	output logic                         pop,
	output logic [1:0]                   busy_clr,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [7:0]                   packet_byte,
	output logic [1:0]                   status,
	output logic                         last
);

	localparam int MEM_DEPTH = 2 * (2 ** POS_W);
	localparam logic [POS_W-1:0] LAST_POS  = POS_W'(PACKET_BYTES - 1);
	localparam logic [POS_W-1:0] FIRST_POS = POS_W'(ccpd_pkg::START_LEN);

	logic [7:0] mem [MEM_DEPTH];

	ccpd_pkg::back_state_t state_q, state_d;
	logic [POS_W-1:0] rd_pos_q;
	logic             cur_buf_q;
	logic             advance, issue_data, rd_last, head_ok;

	logic              valid_s1, last_s1, from_mem_s1;
	ccpd_pkg::status_t status_s1;
	logic [7:0]        pat_s1, rd_data_s1;

	logic       out_valid_q, last_q;
	logic [7:0] packet_byte_q;
	logic [1:0] status_q;

	assign advance = !out_valid_q || !out_stall;
	assign rd_last = rd_pos_q == LAST_POS;
	assign head_ok = head.status == ccpd_pkg::ST_OK;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ccpd_pkg::BK_IDLE: begin
				if (advance && head_valid && head_ok) state_d = ccpd_pkg::BK_EMIT;
			end
			ccpd_pkg::BK_EMIT: begin
				if (advance && rd_last) state_d = ccpd_pkg::BK_IDLE;
			end
			default: state_d = ccpd_pkg::BK_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		pop        = 1'b0;
		issue_data = 1'b0;
		unique case (state_q)
			ccpd_pkg::BK_IDLE: pop        = advance && head_valid;
			ccpd_pkg::BK_EMIT: issue_data = advance;
			default: begin
			end
		endcase
		busy_clr            = '0;
		busy_clr[cur_buf_q] = issue_data && rd_last;
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
	end

	always_ff @(posedge clk) begin
		if (issue_data) rd_data_s1 <= mem[{cur_buf_q, rd_pos_q}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ccpd_pkg::BK_IDLE;
			rd_pos_q    <= '0;
			cur_buf_q   <= 1'b0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop) begin
				rd_pos_q  <= '0;
				cur_buf_q <= head.buf_sel;
			end else if (issue_data) begin
				rd_pos_q <= rd_pos_q + 1'b1;
			end
			if (advance) begin
				valid_s1    <= issue_data || (pop && !head_ok);
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (issue_data) begin
				status_s1   <= ccpd_pkg::ST_OK;
				last_s1     <= rd_last;
				from_mem_s1 <= rd_pos_q >= FIRST_POS;
				pat_s1      <= ccpd_pkg::pattern_byte(start_pattern, rd_pos_q[2:0]);
			end else begin
				status_s1   <= head.status;
				last_s1     <= 1'b1;
				from_mem_s1 <= 1'b0;
				pat_s1      <= '0;
			end
			packet_byte_q <= from_mem_s1 ? rd_data_s1 : pat_s1;
			status_q      <= status_s1;
			last_q        <= last_s1;
		end
	end

	assign out_valid   = out_valid_q;
	assign packet_byte = packet_byte_q;
	assign status      = status_q;
	assign last        = last_q;

endmodule

[rtl/crc_checked_packet_deframer.sv]
// ----------------------------------------------------------------------------
// crc_checked_packet_deframer: fixed-length packet deframer with CRC check
// Finds a five-byte start pattern in a received byte stream, collects a
// fixed-length packet, checks its stop byte and CRC-16/CCITT, and plays out
// good packets byte by byte or a single failure status.
// ----------------------------------------------------------------------------
// Use of the block:
// Received bytes enter on the input channel (in_valid, in_stall, rx_byte), one
// word per accepted cycle; each word is taken at once while hunting for the
// start pattern, but may stall while collecting. Results leave on the
// output channel (out_valid, out_stall, packet_byte, status, last): a good
// packet as PACKET_BYTES words with last on the final one, a stop byte or CRC
// failure as a single word with last set.
// A good packet plays out at one word per cycle while the receiver does not
// stall. Two packet buffers let the next packet be collected while the
// previous one plays out; the input stalls only when both buffers are still
// waiting to be played out or the two-entry descriptor queue is full, so the
// output rate then sets the input rate.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready; index 0 writes the start pattern, index 1 the stop byte.
// Reset clears both registers, empties the queue and returns to hunting.
// When the receiver stalls, the output word holds until it is taken.
// ----------------------------------------------------------------------------
module crc_checked_packet_deframer #(
	parameter int PACKET_BYTES = ccpd_pkg::PACKET_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ccpd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ccpd_pkg::START_W-1:0]   cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [7:0]                     rx_byte,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [7:0]                     packet_byte,
	output logic [1:0]                     status,
	output logic                           last
);

	localparam int POS_W = $clog2(PACKET_BYTES);

	logic [ccpd_pkg::START_W-1:0] start_pattern_q;
	logic [7:0]                   stop_value_q;

	logic             mem_we;
	logic [POS_W:0]   mem_waddr;
	logic [7:0]       mem_wdata;
	logic             push, pop, q_full, head_valid;
	ccpd_pkg::desc_t  push_desc, head;
	logic [1:0]       busy_clr;

	// Configuration is only to be written by the user while the block is idle
	// (unenforced here), so writes need no guarding against packets in flight.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_pattern_q <= '0;
			stop_value_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (ccpd_pkg::cfg_idx_t'(cfg_index))
				ccpd_pkg::CFG_START_PATTERN: start_pattern_q <= cfg_data;
				ccpd_pkg::CFG_STOP_VALUE:    stop_value_q    <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// The front hunts and collects; it writes packet bytes straight into the
	// buffers held by the back and posts one descriptor per finished packet.
	ccpd_front #(
		.PACKET_BYTES (PACKET_BYTES),
		.POS_W        (POS_W)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.start_pattern (start_pattern_q),
		.stop_value    (stop_value_q),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.rx_byte       (rx_byte),
		.mem_we        (mem_we),
		.mem_waddr     (mem_waddr),
		.mem_wdata     (mem_wdata),
		.push          (push),
		.push_desc     (push_desc),
		.q_full        (q_full),
		.busy_clr      (busy_clr)
	);

	ccpd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_desc  (push_desc),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// The back releases a buffer as soon as its last byte has been read, so
	// the front may start refilling it in the following cycle.
	ccpd_back #(
		.PACKET_BYTES (PACKET_BYTES),
		.POS_W        (POS_W)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.start_pattern (start_pattern_q),
		.mem_we        (mem_we),
		.mem_waddr     (mem_waddr),
		.mem_wdata     (mem_wdata),
		.head_valid    (head_valid),
		.head          (head),
		.pop           (pop),
		.busy_clr      (busy_clr),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.packet_byte   (packet_byte),
		.status        (status),
		.last          (last)
	);

endmodule

[bench/ccpd_scoreboard_pkg.sv]
// ----------------------------------------------------------------------------
// ccpd_scoreboard_pkg: expected-word tracking for the packet deframer bench
// Holds an independent model of the deframer (start pattern hunt, packet
// collection, stop byte and CRC-16 checks) and the queue of words it predicts.
// ----------------------------------------------------------------------------
package ccpd_scoreboard_pkg;

	import ccpd_pkg::*;

	localparam int PKT_LEN = PACKET_BYTES_DEF;

	typedef struct {
		logic [7:0] data;
		status_t    st;
		logic       fin;
	} deframed_word_t;

	// CRC-16, polynomial 0x1021, worked out one bit at a time.
	function automatic logic [15:0] crc16_byte(logic [15:0] c, logic [7:0] d);
		logic [15:0] r;
		int          k;
		r = c ^ {d, 8'h00};
		for (k = 0; k < 8; k++)
			r = r[15] ? ((r << 1) ^ 16'h1021) : (r << 1);
		return r;
	endfunction

	class deframer_scoreboard;
		logic [START_W-1:0] start_pattern;
		logic [7:0]         stop_expected;
		logic [31:0]        history;
		bit                 collecting;
		logic [5:0]         pos;
		logic [15:0]        crc;
		logic [7:0]         store [PKT_LEN];
		deframed_word_t     expected_q [$];
		int                 errors;

		function new();
			start_pattern = '0;
			stop_expected = '0;
			history       = '0;
			collecting    = 1'b0;
			pos           = '0;
			crc           = CRC_INIT;
			errors        = 0;
			foreach (store[k])
				store[k] = '0;
		endfunction

		function void write_reg(cfg_idx_t idx, logic [START_W-1:0] value);
			if (idx == CFG_START_PATTERN)
				start_pattern = value;
			else
				stop_expected = value[7:0];
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// One received word taken by the block.
		function void note_word(logic [7:0] b);
			logic [START_W-1:0] window;
			logic [15:0]        rcv;
			deframed_word_t     w;
			int                 i;
			if (!collecting) begin
				window = {history, b};
				if (window == start_pattern) begin
					crc = CRC_INIT;
					for (i = 0; i < START_LEN; i++) begin
						store[i] = start_pattern[8 * (START_LEN - 1 - i) +: 8];
						crc = crc16_byte(crc, store[i]);
					end
					pos        = 6'(START_LEN);
					collecting = 1'b1;
					history    = '0;
				end else begin
					history = window[31:0];
				end
				return;
			end
			store[pos] = b;
			if (pos < PKT_LEN - 3)
				crc = crc16_byte(crc, b);
			if (pos < PKT_LEN - 1) begin
				pos = pos + 6'd1;
				return;
			end
			collecting = 1'b0;
			pos        = '0;
			rcv        = {store[PKT_LEN - 2], store[PKT_LEN - 3]};
			if (b != stop_expected) begin
				w = '{data: 8'h00, st: ST_STOP_ERR, fin: 1'b1};
				expected_q.push_back(w);
			end else if (rcv != crc) begin
				w = '{data: 8'h00, st: ST_CRC_ERR, fin: 1'b1};
				expected_q.push_back(w);
			end else begin
				for (i = 0; i < PKT_LEN; i++) begin
					w = '{data: store[i], st: ST_OK, fin: (i == PKT_LEN - 1)};
					expected_q.push_back(w);
				end
			end
			crc = CRC_INIT;
		endfunction

		function void report(string field, logic [7:0] exp_v, logic [7:0] act_v);
			errors++;
			if (errors <= 40)
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field,
					exp_v, act_v);
		endfunction

		// One result word taken from the block.
		function void check_word(logic [7:0] data, logic [1:0] st, logic fin);
			deframed_word_t w;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 40)
					$display("%0t: word with none expected, expected nothing, actual %0h/%0d/%0b",
						$time, data, st, fin);
				return;
			end
			w = expected_q.pop_front();
			if (data !== w.data)
				report("packet_byte", w.data, data);
			if (st !== w.st)
				report("status", 8'(w.st), 8'(st));
			if (fin !== w.fin)
				report("last", 8'(w.fin), 8'(fin));
		endfunction
	endclass

endpackage

[bench/crc_checked_packet_deframer_tb.sv]
// ----------------------------------------------------------------------------
// crc_checked_packet_deframer_tb: self-checking bench for the packet deframer
// Feeds noise, broken start sequences and framed packets (good, bad CRC, bad
// stop byte, start pattern buried in the payload) under several register
// settings and idle patterns, and checks every output word against a model.
// ----------------------------------------------------------------------------
module crc_checked_packet_deframer_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import ccpd_pkg::*;
	import ccpd_scoreboard_pkg::*;

	localparam int PB          = PACKET_BYTES_DEF;
	localparam int HALF_PERIOD = 5;
	// Quiet cycles after the last expected word, well above the result latency
	// of the block.
	localparam int DRAIN       = 16;
	// Length of the long receiver hold-off used to fill both packet buffers.
	localparam int HOLD_CYCLES = 300;
	// Watchdog bound on the run, many times what a correct run takes even with
	// heavy idling.
	localparam int CYCLE_LIMIT = 200000;

	typedef enum int {
		PK_GOOD,
		PK_BAD_CRC,
		PK_INSIDE,
		PK_BAD_STOP
	} pkt_kind_t;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	cfg_idx_t         cfg_index = CFG_START_PATTERN;
	logic [START_W-1:0] cfg_data = '0;
	logic             in_valid  = 1'b0;
	logic             in_stall;
	logic [7:0]       rx_byte   = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [7:0]       packet_byte;
	logic [1:0]       status;
	logic             last;

	// Idle percentages for the two sides, changed from phase to phase.
	int unsigned      send_idle_pct  = 0;
	int unsigned      stall_pct      = 0;
	logic             hold_go        = 1'b0;
	int               hold_left      = 0;
	int               cycle_count    = 0;

	// Settings last written, used when building packets.
	logic [START_W-1:0] cur_pattern = '0;
	logic [7:0]         cur_stop    = '0;

	deframer_scoreboard sb;

	crc_checked_packet_deframer #(.PACKET_BYTES(PB)) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.packet_byte (packet_byte),
		.status      (status),
		.last        (last)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// Monitors. Inputs are driven with nonblocking assignments at the edge, so
	// the values seen here are those that were present at the edge itself.
	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready)
			sb.write_reg(cfg_index, cfg_data);
		if (arst_n && in_valid && !in_stall)
			sb.note_word(rx_byte);
		if (arst_n && out_valid && !out_stall)
			sb.check_word(packet_byte, status, last);
	end

	// Receiver. A pulse on hold_go starts a long hold-off, counted down here;
	// otherwise the stall is random at the current percentage.
	always @(posedge clk) begin
		if (hold_go)
			hold_left <= HOLD_CYCLES;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
		out_stall <= hold_go || (hold_left > 1) || ($urandom_range(0, 99) < stall_pct);
	end

	// Watchdog: a run that hangs ends here.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("crc_checked_packet_deframer verification failed");
		$finish;
	end

	// Offers one word and returns at the edge that takes it. A random gap may
	// come first; valid is only lowered when such a gap is actually taken.
	task automatic send_word(input logic [7:0] b);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Writes both registers, one word per handshake, while the block is idle.
	task automatic write_config(input logic [START_W-1:0] pattern, input logic [7:0] stop);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_START_PATTERN;
		cfg_data  <= pattern;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_index <= CFG_STOP_VALUE;
		cfg_data  <= {32'h0, stop};
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid   <= 1'b0;
		cur_pattern = pattern;
		cur_stop    = stop;
	endtask

	// Brings the block back to a quiet hunting state: any packet left half
	// collected is finished with filler words, then every expected word is
	// awaited and the DRAIN period lets the pipeline empty.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.collecting) begin
			send_word(8'($urandom));
			in_valid <= 1'b0;
			@(posedge clk);
		end
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	// Words ahead of a packet: plain random bytes, sometimes a start sequence
	// that breaks off one word short of a match or earlier.
	task automatic send_noise();
		int         n;
		int         k;
		int         i;
		logic [7:0] pb;
		n = $urandom_range(0, 4);
		for (i = 0; i < n; i++)
			send_word(8'($urandom));
		if ($urandom_range(0, 2) == 0) begin
			k = $urandom_range(1, START_LEN - 1);
			for (i = 0; i < k; i++)
				send_word(cur_pattern[8 * (START_LEN - 1 - i) +: 8]);
			pb = cur_pattern[8 * (START_LEN - 1 - k) +: 8];
			send_word(pb ^ 8'($urandom_range(1, 255)));
		end
	endtask

	// Builds one framed packet for the current settings and sends it.
	task automatic send_packet(input pkt_kind_t kind);
		logic [7:0]  pkt [PB];
		logic [15:0] c;
		int          i;
		int          at;
		for (i = 0; i < START_LEN; i++)
			pkt[i] = cur_pattern[8 * (START_LEN - 1 - i) +: 8];
		for (i = START_LEN; i < PB - 3; i++)
			pkt[i] = 8'($urandom);
		// A copy of the start pattern in the payload must not restart framing.
		if (kind == PK_INSIDE) begin
			at = $urandom_range(START_LEN, PB - 3 - START_LEN);
			for (i = 0; i < START_LEN; i++)
				pkt[at + i] = pkt[i];
		end
		c = CRC_INIT;
		for (i = 0; i < PB - 3; i++)
			c = crc16_byte(c, pkt[i]);
		pkt[PB - 3] = c[7:0];
		pkt[PB - 2] = c[15:8];
		pkt[PB - 1] = cur_stop;
		if (kind == PK_BAD_CRC) begin
			at = PB - 3 + $urandom_range(0, 1);
			pkt[at] = pkt[at] ^ (8'h01 << $urandom_range(0, 7));
		end
		// A bad stop byte sometimes comes with a bad CRC; the stop check wins.
		if (kind == PK_BAD_STOP) begin
			pkt[PB - 1] = pkt[PB - 1] ^ 8'($urandom_range(1, 255));
			if ($urandom_range(0, 1) == 0)
				pkt[PB - 2] = ~pkt[PB - 2];
		end
		for (i = 0; i < PB; i++)
			send_word(pkt[i]);
	endtask

	initial begin
		logic [START_W-1:0] pat;
		logic [7:0]         stop;
		int                 i;
		int                 ph;
		int                 pk;
		int                 sent;
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. With an all-zero start pattern and the history still
		// cleared from reset, the very first word completes a match. The packet
		// is filled with alternating extreme words and ends on a stop byte that
		// differs from the configured zero, so a stop failure comes out.
		write_config('0, 8'h00);
		send_word(8'h00);
		for (i = START_LEN; i < PB - 1; i++)
			send_word(i[0] ? 8'hFF : 8'h00);
		send_word(8'hFF);
		settle();

		// Random part: four idling phases, each with its own settings and one
		// packet, the four packet kinds taken in turn.
		sent = 0;
		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 0;
					stall_pct     = 0;
				end
				1: begin
					send_idle_pct = 45;
					stall_pct     = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct     = 45;
				end
				default: begin
					send_idle_pct = 29;
					stall_pct     = 29;
				end
			endcase
			pat[39:32] = 8'($urandom);
			pat[31:0]  = $urandom;
			stop       = 8'($urandom);
			case (ph)
				1: begin
					pat  = '1;
					stop = 8'hFF;
				end
				2: stop = 8'h00;
				// Leading zero bytes: a match can come straight from a cleared
				// history, on the last pattern word alone.
				3: pat = {32'h0, 8'($urandom)};
				default: ;
			endcase
			write_config(pat, stop);
			send_noise();
			send_packet(pkt_kind_t'(sent % 4));
			sent++;
			settle();
		end

		// Pressure: the receiver holds off for a long stretch while good packets
		// arrive back to back, so both buffers fill and the input stalls.
		send_idle_pct = 0;
		stall_pct     = 0;
		pat[39:32]    = 8'($urandom);
		pat[31:0]     = $urandom;
		write_config(pat, 8'($urandom));
		hold_go <= 1'b1;
		@(posedge clk);
		hold_go <= 1'b0;
		for (pk = 0; pk < 3; pk++)
			send_packet(PK_GOOD);
		settle();

		if (sb.errors == 0 && sb.pending() == 0)
			$display("crc_checked_packet_deframer verification clean");
		else
			$display("crc_checked_packet_deframer verification failed");
		$finish;
	end

endmodule
